/* rtl/roiou_pkg.sv */
package roiou_pkg;

	localparam int LABEL_W   = 8;
	localparam int OP_W      = 2;
	localparam int CFG_W     = 7;
	localparam int FRAC_BITS = 16;
	localparam int RATIO_W   = FRAC_BITS + 1;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_ACCUM = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	localparam logic REG_TRUE_COUNT = 1'b0;
	localparam logic REG_PRED_COUNT = 1'b1;

endpackage

/* rtl/region_overlap_iou_table_unit.sv */
// channel   | handshake                      | payload
// s_axis    | s_axis_tvalid / s_axis_tready  | tdata: true_label, pred_label; tuser: opcode
// m_axis    | m_axis_tvalid / m_axis_tready  | tdata: isect_count, union_count,
//           |                                |        overlap_ratio; tuser: read_status
// cfg       | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// An accumulate goes through accept, memory read, then read-modify-write.
// A read goes through memory read, union and a restoring divider that resolves
// one quotient bit per cycle, then waits while m_axis has not taken the last result.
// A read whose union is 0 skips the divider.
// A clear, and the reset, run a clearing pass over all MAX_TRUE_REGIONS *
// MAX_PRED_REGIONS pair count entries (4096 by default), zeroing the true
// and pred counts too; s_axis_tready stays low meanwhile. cfg is always ready.
// A finished result waits in the m_axis output register; the next word is
// accepted while it waits.
module region_overlap_iou_table_unit
	import roiou_pkg::*;
#(
	parameter int MAX_TRUE_REGIONS = 64,
	parameter int MAX_PRED_REGIONS = 64,
	parameter int COUNT_BITS       = 22
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,  // [7:0] true_label, [15:8] pred_label
	input  logic [OP_W-1:0]      s_axis_tuser,  // [1:0] opcode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// isect_count, union_count, overlap_ratio from bit 0 up, zero padded
	output logic [((2*COUNT_BITS+RATIO_W+7)/8)*8-1:0] m_axis_tdata,
	output logic                 m_axis_tuser,  // [0] read_status
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CB    = COUNT_BITS;
	localparam int OUT_W = ((2*CB+RATIO_W+7)/8)*8;
	localparam int PAD_W = OUT_W - (2*CB + RATIO_W);
	localparam int TW    = (MAX_TRUE_REGIONS > 1) ? $clog2(MAX_TRUE_REGIONS) : 1;
	localparam int PRW   = (MAX_PRED_REGIONS > 1) ? $clog2(MAX_PRED_REGIONS) : 1;
	localparam int DEPTH = MAX_TRUE_REGIONS * MAX_PRED_REGIONS;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NUM_W = CB + RATIO_W;
	localparam int DCW   = $clog2(RATIO_W);

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_RD, S_UPD, S_UNI, S_DINIT, S_DIV, S_OUT
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    true_cnt_q, pred_cnt_q;
	logic [PW-1:0]       clr_q;
	op_t                 op_q;
	logic                tv_q, pv_q;
	logic [TW-1:0]       tidx_q;
	logic [PRW-1:0]      pidx_q;
	logic [PW-1:0]       paddr_q;
	logic [CB-1:0]       isect_q;
	logic [CB:0]         sum_q;
	logic [CB-1:0]       uni_q;
	logic                status_q;
	logic [CB-1:0]       rem_q;
	logic [RATIO_W-1:0]  qsh_q;
	logic [DCW-1:0]      div_cnt_q;
	logic                m_valid_q;
	logic [OUT_W-1:0]    m_data_q;
	logic                m_user_q;

	logic [CB-1:0] true_mem [MAX_TRUE_REGIONS];
	logic [CB-1:0] pred_mem [MAX_PRED_REGIONS];
	logic [CB-1:0] pair_mem [DEPTH];
	logic [CB-1:0] t_rd_q, p_rd_q, pair_rd_q;

	logic [LABEL_W-1:0] in_t, in_p;
	logic               in_tv, in_pv;
	logic [TW-1:0]      in_tidx;
	logic [PRW-1:0]     in_pidx;
	logic [PW-1:0]      in_paddr;
	logic               clearing, accum_wr;
	logic               t_we, p_we, pair_we;
	logic [TW-1:0]      t_wa;
	logic [PRW-1:0]     p_wa;
	logic [PW-1:0]      pair_wa;
	logic [CB-1:0]      t_wd, p_wd, pair_wd;
	logic [CB:0]        uni_wide;
	logic [CB-1:0]      uni_sat, isect_clamp;
	logic [NUM_W-1:0]   num;
	logic [CB:0]        trial;
	logic               q_bit;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// label checks against the effective region counts
	assign in_t  = s_axis_tdata[7:0];
	assign in_p  = s_axis_tdata[15:8];
	assign in_tv = (in_t != '0) && ({1'b0, in_t} <= {2'b00, true_cnt_q})
		&& ({1'b0, in_t} <= 9'(MAX_TRUE_REGIONS));
	assign in_pv = (in_p != '0) && ({1'b0, in_p} <= {2'b00, pred_cnt_q})
		&& ({1'b0, in_p} <= 9'(MAX_PRED_REGIONS));
	assign in_tidx  = TW'(in_t - 8'd1);
	assign in_pidx  = PRW'(in_p - 8'd1);
	assign in_paddr = PW'(PW'(in_tidx) * PW'(MAX_PRED_REGIONS)) + PW'(in_pidx);

	// memory write ports: clearing pass or saturating increment
	assign clearing = (state_q == S_CLR);
	assign accum_wr = (state_q == S_UPD) && (op_q == OP_ACCUM);

	always_comb begin
		if (clearing) begin
			t_we    = ({1'b0, clr_q} < (PW+1)'(MAX_TRUE_REGIONS));
			p_we    = ({1'b0, clr_q} < (PW+1)'(MAX_PRED_REGIONS));
			pair_we = 1'b1;
			t_wa    = TW'(clr_q);
			p_wa    = PRW'(clr_q);
			pair_wa = clr_q;
			t_wd    = '0;
			p_wd    = '0;
			pair_wd = '0;
		end else begin
			t_we    = accum_wr && tv_q;
			p_we    = accum_wr && pv_q;
			pair_we = accum_wr && tv_q && pv_q;
			t_wa    = tidx_q;
			p_wa    = pidx_q;
			pair_wa = paddr_q;
			t_wd    = (t_rd_q == '1) ? t_rd_q : t_rd_q + CB'(1);
			p_wd    = (p_rd_q == '1) ? p_rd_q : p_rd_q + CB'(1);
			pair_wd = (pair_rd_q == '1) ? pair_rd_q : pair_rd_q + CB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			true_mem[t_wa] <= t_wd;
		end
		t_rd_q <= true_mem[tidx_q];
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			pred_mem[p_wa] <= p_wd;
		end
		p_rd_q <= pred_mem[pidx_q];
	end

	always_ff @(posedge clk) begin
		if (pair_we) begin
			pair_mem[pair_wa] <= pair_wd;
		end
		pair_rd_q <= pair_mem[paddr_q];
	end

	// union with saturation, intersection clamped to it
	assign uni_wide    = (sum_q > {1'b0, isect_q}) ? sum_q - {1'b0, isect_q} : '0;
	assign uni_sat     = uni_wide[CB] ? '1 : uni_wide[CB-1:0];
	assign isect_clamp = (isect_q > uni_sat) ? uni_sat : isect_q;

	// rounded numerator; quotient never exceeds 1.0 since isect <= union
	assign num   = {isect_q, {RATIO_W{1'b0}}} + NUM_W'({uni_q, 1'b0} >> 2)
		- NUM_W'({isect_q, {RATIO_W{1'b0}}} >> 1);
	assign trial = {rem_q, qsh_q[RATIO_W-1]};
	assign q_bit = (trial >= {1'b0, uni_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			true_cnt_q <= CFG_RESET;
			pred_cnt_q <= CFG_RESET;
			m_valid_q  <= 1'b0;
			op_q       <= OP_ACCUM;
			tv_q       <= 1'b0;
			pv_q       <= 1'b0;
			div_cnt_q  <= '0;
			tidx_q     <= '0;
			pidx_q     <= '0;
			paddr_q    <= '0;
			isect_q    <= '0;
			sum_q      <= '0;
			uni_q      <= '0;
			status_q   <= 1'b0;
			rem_q      <= '0;
			qsh_q      <= '0;
			m_data_q   <= '0;
			m_user_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_TRUE_COUNT: true_cnt_q <= cfg_data;
					REG_PRED_COUNT: pred_cnt_q <= cfg_data;
					default: ;
				endcase
			end

			// S_OUT reloads the output register on its own
			if (m_valid_q && m_axis_tready && (state_q != S_OUT)) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == PW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= op_t'(s_axis_tuser);
						tv_q    <= in_tv;
						pv_q    <= in_pv;
						tidx_q  <= in_tidx;
						pidx_q  <= in_pidx;
						paddr_q <= in_paddr;
						case (op_t'(s_axis_tuser))
							OP_ACCUM, OP_READ: state_q <= S_RD;
							OP_CLEAR: begin
								clr_q   <= '0;
								state_q <= S_CLR;
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (op_q == OP_READ) begin
						if (tv_q && pv_q) begin
							isect_q  <= pair_rd_q;
							sum_q    <= {1'b0, t_rd_q} + {1'b0, p_rd_q};
							status_q <= 1'b0;
						end else begin
							isect_q  <= '0;
							sum_q    <= '0;
							status_q <= 1'b1;
						end
						state_q <= S_UNI;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_UNI: begin
					uni_q   <= uni_sat;
					isect_q <= isect_clamp;
					state_q <= S_DINIT;
				end
				S_DINIT: begin
					if (uni_q == '0) begin
						qsh_q   <= '0;
						state_q <= S_OUT;
					end else begin
						rem_q     <= num[NUM_W-1:RATIO_W];
						qsh_q     <= num[RATIO_W-1:0];
						div_cnt_q <= DCW'(RATIO_W - 1);
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					// one quotient bit per cycle, shifted in from the bottom
					rem_q <= q_bit ? CB'(trial - {1'b0, uni_q}) : CB'(trial);
					qsh_q <= {qsh_q[RATIO_W-2:0], q_bit};
					div_cnt_q <= div_cnt_q - DCW'(1);
					if (div_cnt_q == '0) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {{PAD_W{1'b0}}, qsh_q, uni_q, isect_q};
						m_user_q  <= status_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* verif/iou_table_monitor.sv */
`timescale 1ns / 100ps
module iou_table_monitor
	import roiou_pkg::*;
#(
	parameter int MAX_T = 64,
	parameter int MAX_P = 64,
	parameter int CNT_W = 22,
	parameter int OUT_W = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,   // [7:0] true_label, [15:8] pred_label
	input  logic [OP_W-1:0]      s_axis_tuser,   // [1:0] opcode
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [OUT_W-1:0]     m_axis_tdata,   // isect_count, union_count, overlap_ratio
	input  logic                 m_axis_tuser,   // [0] read_status
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic [CNT_W-1:0]   isect;
		logic [CNT_W-1:0]   uni;
		logic [RATIO_W-1:0] ratio;
		logic               status;
	} iou_word_t;

	localparam logic [63:0] CNT_SAT   = (64'd1 << CNT_W) - 64'd1;
	localparam logic [63:0] RATIO_ONE = 64'd1 << FRAC_BITS;

	logic [CNT_W-1:0] pair_cnt  [MAX_T*MAX_P];
	logic [CNT_W-1:0] true_area [MAX_T];
	logic [CNT_W-1:0] pred_area [MAX_P];
	logic [CFG_W-1:0] true_regs;
	logic [CFG_W-1:0] pred_regs;
	iou_word_t        iou_expected [$];

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == CNT_SAT[CNT_W-1:0]) ? c : c + CNT_W'(1);
	endfunction

	function automatic int region_limit(input logic [CFG_W-1:0] r, input int lim);
		return (int'(r) > lim) ? lim : int'(r);
	endfunction

	function automatic iou_word_t iou_of(input logic [63:0] ta, input logic [63:0] pa,
			input logic [63:0] ix);
		logic [63:0] u;
		logic [63:0] i;
		logic [63:0] q;
		iou_word_t   w;
		u = ta + pa;
		u = (u > ix) ? u - ix : 64'd0;
		if (u > CNT_SAT)
			u = CNT_SAT;
		i = (ix > u) ? u : ix;
		q = 64'd0;
		if (u != 64'd0) begin
			// round to nearest, ties up
			q = (i * RATIO_ONE + (u >> 1)) / u;
			if (q > RATIO_ONE)
				q = RATIO_ONE;
		end
		w.isect  = i[CNT_W-1:0];
		w.uni    = u[CNT_W-1:0];
		w.ratio  = q[RATIO_W-1:0];
		w.status = 1'b0;
		return w;
	endfunction

	task automatic zero_counts();
		for (int k = 0; k < MAX_T*MAX_P; k++)
			pair_cnt[k] = '0;
		for (int k = 0; k < MAX_T; k++)
			true_area[k] = '0;
		for (int k = 0; k < MAX_P; k++)
			pred_area[k] = '0;
	endtask

	task automatic compare(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		int        t;
		int        p;
		int        nt;
		int        np;
		logic      tv;
		logic      pv;
		iou_word_t want;
		iou_word_t got;
		if (!arst_n) begin
			zero_counts();
			true_regs = CFG_RESET;
			pred_regs = CFG_RESET;
			iou_expected.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TRUE_COUNT)
					true_regs = cfg_data;
				else
					pred_regs = cfg_data;
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got.isect  = m_axis_tdata[CNT_W-1:0];
				got.uni    = m_axis_tdata[2*CNT_W-1:CNT_W];
				got.ratio  = m_axis_tdata[2*CNT_W+RATIO_W-1:2*CNT_W];
				got.status = m_axis_tuser;
				if (iou_expected.size() == 0) begin
					fail_count++;
					$display("%0t: result word with none expected, expected nothing, got %h/%b",
						$time, m_axis_tdata, m_axis_tuser);
				end else begin
					want = iou_expected.pop_front();
					compare("isect_count", 64'(want.isect), 64'(got.isect));
					compare("union_count", 64'(want.uni), 64'(got.uni));
					compare("overlap_ratio", 64'(want.ratio), 64'(got.ratio));
					compare("read_status", 64'(want.status), 64'(got.status));
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				t  = int'(s_axis_tdata[7:0]);
				p  = int'(s_axis_tdata[15:8]);
				nt = region_limit(true_regs, MAX_T);
				np = region_limit(pred_regs, MAX_P);
				tv = (t >= 1) && (t <= nt);
				pv = (p >= 1) && (p <= np);
				case (s_axis_tuser)
					OP_ACCUM: begin
						if (tv)
							true_area[t-1] = bump(true_area[t-1]);
						if (pv)
							pred_area[p-1] = bump(pred_area[p-1]);
						if (tv && pv)
							pair_cnt[(t-1)*MAX_P + p-1] = bump(pair_cnt[(t-1)*MAX_P + p-1]);
					end
					OP_READ: begin
						if (tv && pv) begin
							iou_expected.push_back(iou_of(64'(true_area[t-1]),
								64'(pred_area[p-1]), 64'(pair_cnt[(t-1)*MAX_P + p-1])));
						end else begin
							want = '0;
							want.status = 1'b1;
							iou_expected.push_back(want);
						end
					end
					OP_CLEAR: zero_counts();
					default: ;
				endcase
			end
			pending <= iou_expected.size();
		end
	end

endmodule

/* verif/region_overlap_iou_table_unit_tb.sv */
`timescale 1ns / 100ps
module region_overlap_iou_table_unit_tb;
	import roiou_pkg::*;

	localparam int MAX_T        = 64;
	localparam int MAX_P        = 64;
	localparam int CNT_W        = 22;
	localparam int OUT_W        = ((2*CNT_W + RATIO_W + 7) / 8) * 8;
	localparam int CLEAR_CYCLES = MAX_T * MAX_P;
	localparam int HOLD_CYCLES  = 600;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata;   // [7:0] true_label, [15:8] pred_label
	logic [OP_W-1:0]      s_axis_tuser;   // [1:0] opcode
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_W-1:0]     m_axis_tdata;   // isect_count, union_count, overlap_ratio
	logic                 m_axis_tuser;   // [0] read_status
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic                 cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int   fail_count;
	int   pending;
	int   cycles = 0;
	int   tx_idle_pct;
	int   rx_idle_pct;
	logic hold_req;
	int   true_eff;
	int   pred_eff;

	region_overlap_iou_table_unit #(
		.MAX_TRUE_REGIONS(MAX_T),
		.MAX_PRED_REGIONS(MAX_P),
		.COUNT_BITS      (CNT_W)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	iou_table_monitor #(
		.MAX_T(MAX_T),
		.MAX_P(MAX_P),
		.CNT_W(CNT_W),
		.OUT_W(OUT_W)
	) u_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("region_overlap_iou_table_unit verification failed");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on each toggle of hold_req
	initial begin : drain
		int   hold_left;
		logic hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_word(input logic [OP_W-1:0] op, input logic [7:0] t, input logic [7:0] p);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {p, t};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_region_counts(input logic [CFG_W-1:0] t, input logic [CFG_W-1:0] p);
		drain_results();
		// a clear may still be sweeping the pair memory
		repeat (CLEAR_CYCLES + 64) @(posedge clk);
		cfg_write(REG_TRUE_COUNT, t);
		cfg_write(REG_PRED_COUNT, p);
		cfg_valid <= 1'b0;
		true_eff = (int'(t) > MAX_T) ? MAX_T : int'(t);
		pred_eff = (int'(p) > MAX_P) ? MAX_P : int'(p);
	endtask

	// mostly a few low regions so reads land on real overlaps
	function automatic logic [7:0] pick_label(input int n);
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 8'd0;
		if (r < 18 || n == 0)
			return 8'($urandom_range(255));
		if (r < 70)
			return 8'($urandom_range((n < 4) ? n : 4, 1));
		if (r < 92)
			return 8'($urandom_range(n, 1));
		return 8'(n + 1);
	endfunction

	task automatic random_phase(input int n);
		int done;
		int len;
		int roll;
		done = 0;
		while (done < n) begin
			roll = $urandom_range(99);
			if (roll < 4) begin
				send_word(OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
				done++;
			end else if (roll < 10) begin
				send_word(OP_IGNORED, 8'($urandom_range(255)), 8'($urandom_range(255)));
			end else begin
				len = $urandom_range(16, 2);
				repeat (len) send_word(OP_ACCUM, pick_label(true_eff), pick_label(pred_eff));
				done += len;
				repeat ($urandom_range(3, 1)) begin
					send_word(OP_READ, pick_label(true_eff), pick_label(pred_eff));
					done++;
				end
			end
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= OP_ACCUM;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_TRUE_COUNT;
		cfg_data      <= CFG_RESET;
		hold_req      <= 1'b0;
		rx_idle_pct   <= 50;
		tx_idle_pct   = 7;
		true_eff      = MAX_T;
		pred_eff      = MAX_P;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// label extremes and out-of-range labels at the reset counts
		send_word(OP_ACCUM, 8'd1, 8'd1);
		send_word(OP_ACCUM, 8'd1, 8'd1);
		send_word(OP_ACCUM, 8'd64, 8'd64);
		send_word(OP_ACCUM, 8'd1, 8'd64);
		send_word(OP_ACCUM, 8'd64, 8'd1);
		send_word(OP_ACCUM, 8'd2, 8'd1);
		send_word(OP_ACCUM, 8'd0, 8'd0);
		send_word(OP_ACCUM, 8'd65, 8'd7);
		send_word(OP_ACCUM, 8'd7, 8'd65);
		send_word(OP_ACCUM, 8'd255, 8'd255);
		send_word(OP_ACCUM, 8'd0, 8'd3);
		send_word(OP_READ, 8'd1, 8'd1);
		send_word(OP_READ, 8'd64, 8'd64);
		send_word(OP_READ, 8'd1, 8'd64);
		send_word(OP_READ, 8'd5, 8'd5);      // empty union
		send_word(OP_READ, 8'd7, 8'd7);      // no overlap
		send_word(OP_READ, 8'd0, 8'd1);
		send_word(OP_READ, 8'd1, 8'd0);
		send_word(OP_READ, 8'd65, 8'd1);
		send_word(OP_READ, 8'd1, 8'd65);
		send_word(OP_READ, 8'd255, 8'd255);
		send_word(OP_IGNORED, 8'd1, 8'd1);
		send_word(OP_READ, 8'd1, 8'd1);
		send_word(OP_CLEAR, 8'd0, 8'd0);
		send_word(OP_READ, 8'd1, 8'd1);

		set_region_counts(7'd1, 7'd1);
		random_phase(70);
		set_region_counts(7'd64, 7'd64);
		random_phase(90);

		tx_idle_pct = 50;
		rx_idle_pct <= 7;
		set_region_counts(7'd127, 7'd100);
		random_phase(80);
		set_region_counts(7'd0, 7'd0);
		random_phase(30);
		set_region_counts(7'd13, 7'd40);
		random_phase(80);

		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		set_region_counts(7'd64, 7'd3);
		// hold the result side while reads keep coming, so the input backs up
		hold_req <= ~hold_req;
		repeat (8) send_word(OP_ACCUM, pick_label(true_eff), pick_label(pred_eff));
		repeat (12) send_word(OP_READ, pick_label(true_eff), pick_label(pred_eff));
		drain_results();
		random_phase(80);
		set_region_counts(7'($urandom_range(127)), 7'($urandom_range(127)));
		random_phase(70);

		drain_results();
		repeat (64) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("region_overlap_iou_table_unit verification clean");
		else
			$display("region_overlap_iou_table_unit verification failed");
		$finish;
	end

endmodule
